// ===== hw/rtl/vfhl_pkg.sv =====
package vfhl_pkg;

  localparam int unsigned CoordW  = 48;
  localparam int unsigned VsW     = 30;
  localparam int unsigned TagW    = 32;
  localparam int unsigned LabelW  = 19;
  localparam int unsigned StoreW  = 18;
  localparam int unsigned LabelDepth = 262144;
  localparam int unsigned AddrW   = 18;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DimDefault = 64;
  localparam int unsigned DimW    = 13;
  localparam int unsigned EpochW  = 8;

  localparam logic [VsW-1:0] VoxelSizeReset = 30'd6554;

  typedef enum logic [CfgIdxW-1:0] {
    RegVoxelSize = 3'd0,
    RegGridMode  = 3'd1,
    RegBaseX     = 3'd2,
    RegBaseY     = 3'd3,
    RegBaseZ     = 3'd4,
    RegMinX      = 3'd5,
    RegMinY      = 3'd6,
    RegMinZ      = 3'd7
  } cfg_reg_e;

  // Control handed from the front end to the divider.
  typedef struct packed {
    logic            start;
    logic [CoordW:0] dividend;
    logic            neg;
  } div_req_t;

endpackage

// ===== hw/rtl/vfhl_if.sv =====
interface vfhl_point_if;
  logic                           valid;
  logic                           ready;
  logic signed [vfhl_pkg::CoordW-1:0] coord_x;
  logic signed [vfhl_pkg::CoordW-1:0] coord_y;
  logic signed [vfhl_pkg::CoordW-1:0] coord_z;
  logic [vfhl_pkg::TagW-1:0]      point_index;
  logic                           scene_start;
  modport source (output valid, coord_x, coord_y, coord_z, point_index, scene_start,
                  input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, point_index, scene_start,
                output ready);
endinterface

interface vfhl_label_if;
  logic                            valid;
  logic                            ready;
  logic [vfhl_pkg::TagW-1:0]       point_tag;
  logic [vfhl_pkg::LabelW-1:0]     cluster_id;
  logic                            new_cluster;
  logic                            out_of_grid;
  modport source (output valid, point_tag, cluster_id, new_cluster, out_of_grid,
                  input ready);
  modport sink (input valid, point_tag, cluster_id, new_cluster, out_of_grid,
                output ready);
endinterface

interface vfhl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vfhl_pkg::CfgIdxW-1:0]    index;
  logic [63:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/vfhl_div.sv =====
// Restoring divider, one quotient bit per cycle. Dividend is non-negative
// (49 bits); divisor is the voxel size. Result is the floor quotient, or
// the ceiling quotient when neg is set, and the remainder of the division.
module vfhl_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  vfhl_pkg::div_req_t              req_i,
  input  logic [vfhl_pkg::VsW-1:0]        divisor_i,
  output logic                            done_o,
  output logic [vfhl_pkg::CoordW:0]       quot_o,
  output logic [vfhl_pkg::VsW-1:0]        rem_o
);
  localparam int unsigned NW = vfhl_pkg::CoordW + 1;
  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]   num_q, num_d, quot_q, quot_d;
  logic [vfhl_pkg::VsW:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [vfhl_pkg::VsW:0] trial;

  always_comb begin
    num_d = num_q; quot_d = quot_q; rem_d = rem_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q; done_d = 1'b0;
    trial = {rem_q[vfhl_pkg::VsW-1:0], num_q[NW-1]};
    if (req_i.start) begin
      num_d = req_i.dividend; quot_d = '0; rem_d = '0;
      cnt_d = CntW'(NW); busy_d = 1'b1; neg_d = req_i.neg;
    end else if (busy_q) begin
      num_d = {num_q[NW-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d  = trial - {1'b0, divisor_i};
        quot_d = {quot_q[NW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
    // Ceiling correction when the quotient is for a negative difference.
    if (done_q && neg_q && (rem_q != '0)) quot_o = quot_q + 1'b1;
    else quot_o = quot_q;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[vfhl_pkg::VsW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; quot_q <= quot_d; rem_q <= rem_d; neg_q <= neg_d;
  end
endmodule

// ===== hw/rtl/vfhl_store.sv =====
// Label store: synchronous memory with an epoch mark per entry, so a scene
// start invalidates every entry without a sweep except when the mark wraps. Reads are registered.
module vfhl_store (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [vfhl_pkg::AddrW-1:0]    rd_addr_i,
  output logic [vfhl_pkg::EpochW+vfhl_pkg::StoreW-1:0] rd_data_o,
  input  logic                          wr_en_i,
  input  logic [vfhl_pkg::AddrW-1:0]    wr_addr_i,
  input  logic [vfhl_pkg::EpochW+vfhl_pkg::StoreW-1:0] wr_data_i
);
  logic [vfhl_pkg::EpochW+vfhl_pkg::StoreW-1:0] mem [vfhl_pkg::LabelDepth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_o <= mem[rd_addr_i];
  end
endmodule

// ===== hw/rtl/voxel_first_hit_labeler.sv =====
// Channel | Dir | Handshake   | Payload
// pnt     | in  | valid/ready | coord_x/y/z, point_index, scene_start
// lbl     | out | valid/ready | point_tag, cluster_id, new_cluster, out_of_grid
// cfg     | in  | valid/ready | index, data
// One item at a time. Each axis runs on the shared serial divider (start,
// 49 quotient bits, done); then the states StAddr, StRead (store read) and
// StUpd (update) give the result, and the next item can be accepted as soon
// as that result sits in the output register.
// A scene start in mode 1 adds one divider run per axis to snap the origin.
// The label store uses an epoch mark; at reset and at every 255th scene start
// a clearing pass over all 262144 entries runs while no item is accepted.
// The result sits in an output register; the next item is accepted while it waits,
// and only the update of that next item stalls until the waiting result is taken.
module voxel_first_hit_labeler #(
  parameter int unsigned DIM_X = vfhl_pkg::DimDefault,
  parameter int unsigned DIM_Y = vfhl_pkg::DimDefault,
  parameter int unsigned DIM_Z = vfhl_pkg::DimDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  vfhl_point_if.sink   pnt,
  vfhl_label_if.source lbl,
  vfhl_cfg_if.sink     cfg
);
  localparam int unsigned CW = vfhl_pkg::CoordW;
  localparam int unsigned SW = vfhl_pkg::StoreW;
  localparam int unsigned EW = vfhl_pkg::EpochW;
  localparam int unsigned AW = vfhl_pkg::AddrW;
  localparam int unsigned LW = 3 * vfhl_pkg::DimW;

  typedef enum logic [8:0] {
    StClear  = 9'b000000001,
    StIdle   = 9'b000000010,
    StSnapGo = 9'b000000100,
    StSnapW  = 9'b000001000,
    StAxGo   = 9'b000010000,
    StAxW    = 9'b000100000,
    StAddr   = 9'b001000000,
    StRead   = 9'b010000000,
    StUpd    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [vfhl_pkg::VsW-1:0] vs_q;
  logic                     mode_q;
  logic signed [CW-1:0]     base_q [3];
  logic signed [CW-1:0]     smin_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= vfhl_pkg::VoxelSizeReset;
      mode_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        base_q[i] <= '0;
        smin_q[i] <= '0;
      end
    end else if (cfg.valid) begin
      unique case (vfhl_pkg::cfg_reg_e'(cfg.index))
        vfhl_pkg::RegVoxelSize: vs_q <= cfg.data[vfhl_pkg::VsW-1:0];
        vfhl_pkg::RegGridMode:  mode_q <= cfg.data[0];
        vfhl_pkg::RegBaseX:     base_q[0] <= cfg.data[CW-1:0];
        vfhl_pkg::RegBaseY:     base_q[1] <= cfg.data[CW-1:0];
        vfhl_pkg::RegBaseZ:     base_q[2] <= cfg.data[CW-1:0];
        vfhl_pkg::RegMinX:      smin_q[0] <= cfg.data[CW-1:0];
        vfhl_pkg::RegMinY:      smin_q[1] <= cfg.data[CW-1:0];
        vfhl_pkg::RegMinZ:      smin_q[2] <= cfg.data[CW-1:0];
        default: ;
      endcase
    end
  end
  assign cfg.ready = 1'b1;

  // Working registers.
  logic signed [CW:0]     org_q [3], org_d [3];
  logic signed [CW-1:0]   crd_q [3];
  logic [vfhl_pkg::TagW-1:0] tag_q;
  logic [1:0]             ax_q, ax_d;
  logic                   oog_q, oog_d;
  logic [vfhl_pkg::DimW-1:0] idx_q [3], idx_d [3];
  logic [AW-1:0]          addr_q, addr_d;
  logic [AW:0]            clr_q, clr_d;
  logic [EW-1:0]          epoch_q, epoch_d;
  logic [vfhl_pkg::LabelW-1:0] next_q, next_d;
  logic                   ov_q, ov_d;
  logic [vfhl_pkg::TagW-1:0] otag_q;
  logic [vfhl_pkg::LabelW-1:0] oid_q, oid_d;
  logic                   onew_q, onew_d, ooog_q, ooog_d;

  vfhl_pkg::div_req_t dreq;
  logic               ddone;
  logic [CW:0]        dquot;
  logic [vfhl_pkg::VsW-1:0] drem;
  logic signed [CW+1:0] diff;
  logic [CW+1:0]      mag;
  logic [LW-1:0]      lin;
  logic               accept;

  // Store ports.
  logic          rd_en, wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW+SW-1:0] rd_data, wr_data;

  vfhl_store u_store (
    .clk_i, .rd_en_i(rd_en), .rd_addr_i(addr_q), .rd_data_o(rd_data),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data)
  );

  vfhl_div u_div (
    .clk_i, .rst_ni, .req_i(dreq), .divisor_i(vs_q), .done_o(ddone), .quot_o(dquot),
    .rem_o(drem)
  );

  assign accept = pnt.valid && pnt.ready;
  assign pnt.ready = (state_q == StIdle);

  always_comb begin
    state_d = state_q; ax_d = ax_q; oog_d = oog_q; addr_d = addr_q;
    clr_d = clr_q; epoch_d = epoch_q; next_d = next_q; ov_d = ov_q;
    oid_d = oid_q; onew_d = onew_q; ooog_d = ooog_q;
    for (int i = 0; i < 3; i++) begin
      org_d[i] = org_q[i];
      idx_d[i] = idx_q[i];
    end
    dreq = '0; rd_en = 1'b0; wr_en = 1'b0;
    wr_addr = addr_q; wr_data = '0;
    diff = '0; mag = '0;
    lin = '0;
    if (lbl.ready) ov_d = 1'b0;

    unique case (state_q)
      StClear: begin
        wr_en = 1'b1;
        wr_addr = clr_q[AW-1:0];
        clr_d = clr_q + 1'b1;
        // Epoch 0 marks the pass after reset; otherwise a point is waiting.
        if (clr_q == (AW+1)'(vfhl_pkg::LabelDepth - 1)) begin
          state_d = (epoch_q == '0) ? StIdle : StSnapGo;
          epoch_d = EW'(1);
        end
      end
      StIdle: begin
        if (accept) begin
          ax_d = '0;
          oog_d = 1'b0;
          if (pnt.scene_start) begin
            next_d = vfhl_pkg::LabelW'(1);
            if (mode_q == 1'b0 || vs_q == '0) begin
              for (int i = 0; i < 3; i++) org_d[i] = {smin_q[i][CW-1], smin_q[i]};
            end
            if (epoch_q == {EW{1'b1}}) begin
              clr_d = '0;
              state_d = StClear;
            end else begin
              epoch_d = epoch_q + 1'b1;
              state_d = (mode_q && vs_q != '0) ? StSnapGo : StAxGo;
            end
          end else begin
            state_d = StAxGo;
          end
        end
      end
      StSnapGo: begin
        if (mode_q && vs_q != '0) begin
          diff = (CW+2)'(smin_q[ax_q]) - (CW+2)'(base_q[ax_q]);
          mag = diff[CW+1] ? (CW+2)'(-diff) : (CW+2)'(diff);
          dreq.start = 1'b1;
          dreq.dividend = mag[CW:0];
          dreq.neg = diff[CW+1];
          state_d = StSnapW;
        end else begin
          for (int i = 0; i < 3; i++) org_d[i] = {smin_q[i][CW-1], smin_q[i]};
          ax_d = '0;
          state_d = StAxGo;
        end
      end
      StSnapW: begin
        if (ddone) begin
          diff = (CW+2)'(smin_q[ax_q]) - (CW+2)'(base_q[ax_q]);
          // Step down from the minimum to the lattice point at or below it.
          if (diff[CW+1] && (drem != '0))
            org_d[ax_q] = (CW+1)'((CW+2)'(smin_q[ax_q]) - (CW+2)'(vs_q)
                                  + (CW+2)'(drem));
          else
            org_d[ax_q] = (CW+1)'((CW+2)'(smin_q[ax_q]) - (CW+2)'(drem));
          if (ax_q == 2'd2) begin
            ax_d = '0;
            state_d = StAxGo;
          end else begin
            ax_d = ax_q + 1'b1;
            state_d = StSnapGo;
          end
        end
      end
      StAxGo: begin
        diff = (CW+2)'(crd_q[ax_q]) - (CW+2)'(org_q[ax_q]);
        if (vs_q == '0 || diff[CW+1]) begin
          oog_d = 1'b1;
          state_d = StAddr;
        end else begin
          dreq.start = 1'b1;
          dreq.dividend = diff[CW:0];
          dreq.neg = 1'b0;
          state_d = StAxW;
        end
      end
      StAxW: begin
        if (ddone) begin
          if ((ax_q == 2'd0 && dquot >= (CW+1)'(DIM_X)) ||
              (ax_q == 2'd1 && dquot >= (CW+1)'(DIM_Y)) ||
              (ax_q == 2'd2 && dquot >= (CW+1)'(DIM_Z))) begin
            oog_d = 1'b1;
            state_d = StAddr;
          end else begin
            idx_d[ax_q] = dquot[vfhl_pkg::DimW-1:0];
            if (ax_q == 2'd2) state_d = StAddr;
            else begin
              ax_d = ax_q + 1'b1;
              state_d = StAxGo;
            end
          end
        end
      end
      StAddr: begin
        lin = (LW'(idx_q[2]) * LW'(DIM_Y) + LW'(idx_q[1])) * LW'(DIM_X)
              + LW'(idx_q[0]);
        if (!oog_q && lin >= LW'(vfhl_pkg::LabelDepth)) oog_d = 1'b1;
        addr_d = lin[AW-1:0];
        state_d = StRead;
      end
      StRead: begin
        rd_en = !oog_q;
        state_d = StUpd;
      end
      StUpd: begin
        // Hold while the previous result still waits in the output register.
        if (!ov_q || lbl.ready) begin
          if (oog_q) begin
            oid_d = '0; onew_d = 1'b0; ooog_d = 1'b1;
          end else if (rd_data[EW+SW-1:SW] == epoch_q) begin
            oid_d = vfhl_pkg::LabelW'(rd_data[SW-1:0]) + 1'b1;
            onew_d = 1'b0; ooog_d = 1'b0;
          end else begin
            wr_en = 1'b1;
            wr_data = {epoch_q, SW'(next_q - 1'b1)};
            oid_d = next_q; onew_d = 1'b1; ooog_d = 1'b0;
            next_d = next_q + 1'b1;
          end
          ov_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      epoch_q <= '0;
      next_q <= vfhl_pkg::LabelW'(1);
      ov_q <= 1'b0;
      ax_q <= '0;
      oog_q <= 1'b0;
      for (int i = 0; i < 3; i++) org_q[i] <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      epoch_q <= epoch_d;
      next_q <= next_d;
      ov_q <= ov_d;
      ax_q <= ax_d;
      oog_q <= oog_d;
      for (int i = 0; i < 3; i++) org_q[i] <= org_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    for (int i = 0; i < 3; i++) idx_q[i] <= idx_d[i];
    if (accept) begin
      crd_q[0] <= pnt.coord_x;
      crd_q[1] <= pnt.coord_y;
      crd_q[2] <= pnt.coord_z;
      tag_q <= pnt.point_index;
    end
    if (state_q == StUpd && state_d == StIdle) begin
      oid_q <= oid_d; onew_q <= onew_d; ooog_q <= ooog_d;
      otag_q <= tag_q;
    end
  end

  assign lbl.valid = ov_q;
  assign lbl.point_tag = otag_q;
  assign lbl.cluster_id = oid_q;
  assign lbl.new_cluster = onew_q;
  assign lbl.out_of_grid = ooog_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !accept) else $error("item taken while busy");
  a_oog_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ooog_q) |-> (oid_q == '0 && !onew_q)) else $error("bad out-of-grid label");
  a_new_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StUpd && state_d == StIdle && onew_d) |=>
    (next_q == $past(next_q) + 1'b1))
    else $error("numbering did not advance");
`endif
endmodule
